@@ hw/rtl/prq_pkg.sv @@
// shared types and codes of the priority ready queue scheduler
package prq_pkg;

    localparam int PRIO_W  = 5;
    localparam int QUANT_W = 8;
    localparam int SUSP_W  = 8;

    localparam logic [3:0] FN_CREATE  = 4'd0;
    localparam logic [3:0] FN_READY   = 4'd1;
    localparam logic [3:0] FN_DISPATCH = 4'd2;
    localparam logic [3:0] FN_PREEMPT = 4'd3;
    localparam logic [3:0] FN_SUSPEND = 4'd4;
    localparam logic [3:0] FN_RESUME  = 4'd5;
    localparam logic [3:0] FN_SETPRI  = 4'd6;
    localparam logic [3:0] FN_BLOCK   = 4'd7;
    localparam logic [3:0] FN_YIELD   = 4'd8;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_READY = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_SUSP  = 3'd5;
    localparam logic [2:0] ST_TRANS = 3'd6;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_READY = 2'd1;
    localparam logic [1:0] STS_ALREADY  = 2'd2;
    localparam logic [1:0] STS_BAD_PRIO = 2'd3;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_CEILING = 1'b1;

    typedef struct packed {
        logic [3:0] func;
        logic [4:0] thread_id;
        logic [6:0] charge;
        logic [4:0] boost;
        logic [4:0] new_priority;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic       sel_valid;
        logic [4:0] sel_thread;
        logic       hint;
        logic [7:0] prev_susp;
    } t_result;

    typedef struct packed {
        logic [6:0] quantum_reload;
        logic [4:0] boost_ceiling;
    } t_cfg;

endpackage

@@ hw/rtl/prq_core.sv @@
// thread table, ready queues and the combinational operation logic
module prq_core #(
    parameter int NUM_THREADS     = 32,
    parameter int PRIORITY_LEVELS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  prq_pkg::t_item   i_item,
    input  prq_pkg::t_cfg    i_cfg,
    output prq_pkg::t_result o_res
);
    localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int LW = TW + 1;
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam logic [LW-1:0] NIL = {LW{1'b1}};

    typedef struct packed {
        logic [NUM_THREADS-1:0][prq_pkg::PRIO_W-1:0]  dyn;
        logic [NUM_THREADS-1:0][prq_pkg::PRIO_W-1:0]  base;
        logic [NUM_THREADS-1:0][prq_pkg::QUANT_W-1:0] quant;
        logic [NUM_THREADS-1:0][2:0]                  st;
        logic [NUM_THREADS-1:0][prq_pkg::SUSP_W-1:0]  susp;
        logic [NUM_THREADS-1:0][LW-1:0]               nxt;
        logic [NUM_THREADS-1:0][LW-1:0]               prv;
        logic [PRIORITY_LEVELS-1:0][LW-1:0]           head;
        logic [PRIORITY_LEVELS-1:0][LW-1:0]           tail;
        logic [PRIORITY_LEVELS-1:0]                   map;
        logic [TW-1:0]                                run;
    } t_state;

    t_state r_s, n_s;
    t_state w_rst;

    function automatic logic [PW-1:0] f_lvl(input logic [prq_pkg::PRIO_W-1:0] p);
        if (int'(p) < PRIORITY_LEVELS) return PW'(p);
        return PW'(PRIORITY_LEVELS - 1);
    endfunction

    function automatic logic f_is_thr(input logic [LW-1:0] l);
        return int'(l) < NUM_THREADS;
    endfunction

    function automatic t_state f_unlink(input t_state s, input logic [TW-1:0] t);
        logic [PW-1:0] p;
        logic [LW-1:0] n, pv;
        p  = f_lvl(s.dyn[t]);
        n  = s.nxt[t];
        pv = s.prv[t];
        if (f_is_thr(n))  s.prv[n[TW-1:0]] = pv;
        if (f_is_thr(pv)) s.nxt[pv[TW-1:0]] = n;
        if (s.head[p] == LW'(t)) s.head[p] = n;
        if (s.tail[p] == LW'(t)) s.tail[p] = pv;
        if (s.tail[p] == NIL) s.map[p] = 1'b0;
        s.nxt[t] = NIL;
        s.prv[t] = NIL;
        return s;
    endfunction

    function automatic t_state f_ins_head(input t_state s, input logic [TW-1:0] t);
        logic [PW-1:0] p;
        logic [LW-1:0] h;
        p = f_lvl(s.dyn[t]);
        h = s.head[p];
        s.prv[t] = NIL;
        if (!f_is_thr(h)) begin
            s.nxt[t]  = NIL;
            s.head[p] = LW'(t);
            s.tail[p] = LW'(t);
            s.map[p]  = 1'b1;
        end else begin
            s.nxt[t]          = h;
            s.prv[h[TW-1:0]]  = LW'(t);
            s.head[p]         = LW'(t);
        end
        return s;
    endfunction

    function automatic t_state f_ins_tail(input t_state s, input logic [TW-1:0] t);
        logic [PW-1:0] p;
        logic [LW-1:0] tl;
        p  = f_lvl(s.dyn[t]);
        tl = s.tail[p];
        s.nxt[t] = NIL;
        if (!f_is_thr(tl)) begin
            s.prv[t]  = NIL;
            s.head[p] = LW'(t);
            s.tail[p] = LW'(t);
            s.map[p]  = 1'b1;
        end else begin
            s.prv[t]          = tl;
            s.nxt[tl[TW-1:0]] = LW'(t);
            s.tail[p]         = LW'(t);
        end
        return s;
    endfunction

    function automatic t_state f_detach(input t_state s, input logic [TW-1:0] t);
        if (s.st[t] == prq_pkg::ST_READY) begin
            s       = f_unlink(s, t);
            s.st[t] = prq_pkg::ST_TRANS;
        end
        return s;
    endfunction

    function automatic t_state f_decay(input t_state s, input logic [TW-1:0] t,
                                       input logic [6:0] reload);
        s.quant[t] = {1'b0, reload};
        if (s.dyn[t] > s.base[t]) s.dyn[t] = s.dyn[t] - 1'b1;
        return s;
    endfunction

    function automatic t_state f_ready(input t_state s, input logic [TW-1:0] t,
                                       input logic [6:0] charge, input logic [4:0] boost,
                                       input prq_pkg::t_cfg cfg,
                                       output logic [1:0] sts, output logic hint);
        logic [prq_pkg::QUANT_W-1:0] q;
        logic [prq_pkg::PRIO_W:0]    np;
        logic [prq_pkg::PRIO_W:0]    cap;
        sts  = prq_pkg::STS_OK;
        hint = 1'b0;
        if (s.susp[t] != '0) begin
            s.st[t] = prq_pkg::ST_SUSP;
        end else if (s.st[t] == prq_pkg::ST_READY) begin
            sts = prq_pkg::STS_ALREADY;
        end else begin
            q   = ({1'b0, charge} >= s.quant[t]) ? '0 : s.quant[t] - {1'b0, charge};
            np  = {1'b0, s.base[t]} + {1'b0, boost};
            cap = (prq_pkg::PRIO_W + 1)'(f_lvl(cfg.boost_ceiling));
            if (np > cap) np = cap;
            if (np > {1'b0, s.dyn[t]}) s.dyn[t] = np[prq_pkg::PRIO_W-1:0];
            s.st[t] = prq_pkg::ST_READY;
            if (q != '0) begin
                s.quant[t] = q;
                s = f_ins_head(s, t);
            end else begin
                s = f_decay(s, t, cfg.quantum_reload);
                s = f_ins_tail(s, t);
            end
            hint = s.dyn[t] > s.dyn[s.run];
        end
        return s;
    endfunction

    function automatic t_state f_dispatch(input t_state s, output logic [1:0] sts,
                                          output logic sv, output logic [4:0] sel);
        logic [PW-1:0] pick;
        logic [LW-1:0] t;
        pick = '0;
        sts  = prq_pkg::STS_NO_READY;
        sv   = 1'b0;
        sel  = '0;
        for (int p = 0; p < PRIORITY_LEVELS; p++) begin
            if (s.map[p]) pick = PW'(p);
        end
        t = s.head[pick];
        if (s.map != '0 && f_is_thr(t)) begin
            s                 = f_unlink(s, t[TW-1:0]);
            s.st[t[TW-1:0]]   = prq_pkg::ST_RUN;
            s.run             = t[TW-1:0];
            sts               = prq_pkg::STS_OK;
            sv                = 1'b1;
            sel               = 5'(t[TW-1:0]);
        end
        return s;
    endfunction

    always_comb begin
        w_rst = '0;
        for (int i = 0; i < NUM_THREADS; i++) begin
            w_rst.nxt[i] = NIL;
            w_rst.prv[i] = NIL;
        end
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            w_rst.head[i] = NIL;
            w_rst.tail[i] = NIL;
        end
    end

    always_comb begin
        t_state                     s;
        logic [TW-1:0]              t;
        logic [TW-1:0]              r;
        logic [1:0]                 sts;
        logic                       hint;
        logic                       dummy;
        logic [prq_pkg::SUSP_W-1:0] prev;
        logic                       bad_tid;
        s     = r_s;
        t     = TW'(i_item.thread_id);
        r     = r_s.run;
        o_res = '0;
        sts   = prq_pkg::STS_OK;
        hint  = 1'b0;
        dummy = 1'b0;
        prev  = '0;
        bad_tid = (i_item.func == prq_pkg::FN_CREATE || i_item.func == prq_pkg::FN_READY ||
                   i_item.func == prq_pkg::FN_SUSPEND || i_item.func == prq_pkg::FN_RESUME ||
                   i_item.func == prq_pkg::FN_SETPRI) &&
                  (int'(i_item.thread_id) >= NUM_THREADS);
        if (!bad_tid) begin
            case (i_item.func)
                prq_pkg::FN_CREATE: begin
                    if (int'(i_item.new_priority) >= PRIORITY_LEVELS) begin
                        sts = prq_pkg::STS_BAD_PRIO;
                    end else begin
                        s          = f_detach(s, t);
                        s.dyn[t]   = i_item.new_priority;
                        s.base[t]  = i_item.new_priority;
                        s.quant[t] = {1'b0, i_cfg.quantum_reload};
                        s.susp[t]  = '0;
                        s.st[t]    = prq_pkg::ST_INIT;
                        s = f_ready(s, t, '0, '0, i_cfg, sts, hint);
                    end
                end
                prq_pkg::FN_READY: begin
                    s = f_ready(s, t, i_item.charge, i_item.boost, i_cfg, sts, hint);
                end
                prq_pkg::FN_DISPATCH: begin
                    s = f_dispatch(s, sts, o_res.sel_valid, o_res.sel_thread);
                end
                prq_pkg::FN_PREEMPT: begin
                    s = f_detach(s, r);
                    if (s.quant[r] == '0) s = f_decay(s, r, i_cfg.quantum_reload);
                    s.st[r] = prq_pkg::ST_READY;
                    s = f_ins_tail(s, r);
                    s = f_dispatch(s, sts, o_res.sel_valid, o_res.sel_thread);
                end
                prq_pkg::FN_SUSPEND: begin
                    prev = s.susp[t];
                    if (prev != '1) s.susp[t] = prev + 1'b1;
                    if (prev == '0) begin
                        if (s.st[t] == prq_pkg::ST_READY) begin
                            s       = f_unlink(s, t);
                            s.st[t] = prq_pkg::ST_SUSP;
                        end else if (s.st[t] == prq_pkg::ST_RUN) begin
                            s.st[t] = prq_pkg::ST_SUSP;
                            s = f_dispatch(s, sts, o_res.sel_valid, o_res.sel_thread);
                        end
                    end
                end
                prq_pkg::FN_RESUME: begin
                    prev = s.susp[t];
                    if (prev != '0) begin
                        s.susp[t] = prev - 1'b1;
                        if (prev == 8'd1 && (s.st[t] == prq_pkg::ST_SUSP ||
                                             s.st[t] == prq_pkg::ST_INIT)) begin
                            s = f_ready(s, t, '0, '0, i_cfg, sts, hint);
                        end
                    end
                end
                prq_pkg::FN_SETPRI: begin
                    if (int'(i_item.new_priority) >= PRIORITY_LEVELS) begin
                        sts = prq_pkg::STS_BAD_PRIO;
                    end else if (s.base[t] != i_item.new_priority) begin
                        if (s.st[t] == prq_pkg::ST_READY) begin
                            s         = f_unlink(s, t);
                            s.dyn[t]  = i_item.new_priority;
                            s.base[t] = i_item.new_priority;
                            s.st[t]   = prq_pkg::ST_TRANS;
                            s = f_ready(s, t, '0, '0, i_cfg, sts, hint);
                        end else if (t == r && i_item.new_priority < s.dyn[t]) begin
                            // lowering the running thread gives the cpu back
                            s.dyn[t]  = i_item.new_priority;
                            s.base[t] = i_item.new_priority;
                            s = f_ready(s, t, '0, '0, i_cfg, sts, dummy);
                            s = f_dispatch(s, sts, o_res.sel_valid, o_res.sel_thread);
                        end else begin
                            s.dyn[t]  = i_item.new_priority;
                            s.base[t] = i_item.new_priority;
                        end
                    end
                end
                prq_pkg::FN_BLOCK: begin
                    s       = f_detach(s, r);
                    s.st[r] = prq_pkg::ST_WAIT;
                    s = f_dispatch(s, sts, o_res.sel_valid, o_res.sel_thread);
                end
                prq_pkg::FN_YIELD: begin
                    s          = f_detach(s, r);
                    s.quant[r] = '0;
                    s = f_ready(s, r, '0, '0, i_cfg, sts, dummy);
                    s = f_dispatch(s, sts, o_res.sel_valid, o_res.sel_thread);
                end
                default: begin
                end
            endcase
        end
        o_res.status    = sts;
        o_res.hint      = hint;
        o_res.prev_susp = prev;
        n_s             = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= w_rst;
        end else if (i_en) begin
            r_s <= n_s;
        end
    end

    logic [PRIORITY_LEVELS-1:0] w_head_live;
    always_comb begin
        for (int p = 0; p < PRIORITY_LEVELS; p++) begin
            w_head_live[p] = r_s.head[p] != NIL;
        end
    end

    a_map_matches_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s.map == w_head_live) else $error("nonempty map out of step with queue heads");

    a_select_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.sel_valid) |-> o_res.status == prq_pkg::STS_OK)
        else $error("dispatch with bad status");

    a_select_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.sel_valid) |=> r_s.st[r_s.run] == prq_pkg::ST_RUN)
        else $error("dispatched thread not running");

    a_hint_no_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |-> !(o_res.sel_valid && o_res.hint)) else $error("hint on dispatch");

endmodule

@@ hw/rtl/priority_ready_queue_scheduler.sv @@
// top level of the priority ready queue thread scheduler
// Usage: each item on the input channel (i_in_valid / o_in_ready) is one
// scheduler operation: create, ready, dispatch, preempt, suspend, resume,
// set priority, block or yield, with its thread id, charge, boost and
// priority. Every item gives exactly one result item on the output channel
// (o_out_valid / i_out_ready): status, the dispatched thread, the preempt
// hint and the suspend count seen before suspend or resume.
// An accepted item waits in the input register while the whole operation
// (a few queue unlinks and inserts and one priority encode of the nonempty
// map) runs in one pass; the result is registered, so o_out_valid rises
// once the item has moved from the input register into the result
// register. One item is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one; o_in_ready drops only while both are
// full. Reset (synchronous, active low) empties both registers, clears the
// thread table and all queues, makes thread 0 the running thread and loads
// a quantum reload of 36 and a boost ceiling of 15. The two registers are
// written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while the block is idle, which the block does not enforce.
module priority_ready_queue_scheduler #(
    parameter int NUM_THREADS     = 32,
    parameter int PRIORITY_LEVELS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_func,
    input  logic [4:0] i_thread_id,
    input  logic [6:0] i_charge,
    input  logic [4:0] i_boost,
    input  logic [4:0] i_new_priority,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic       o_selected_valid,
    output logic [4:0] o_selected_thread,
    output logic       o_preempt_hint,
    output logic [7:0] o_prev_suspend_count
);
    logic             r_in_v;
    prq_pkg::t_item   r_in;
    logic             r_out_v;
    prq_pkg::t_result r_res;
    prq_pkg::t_result w_res;
    prq_pkg::t_cfg    r_cfg;
    logic             w_adv;

    assign w_adv      = r_in_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_in_v || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quantum_reload <= 7'd36;
            r_cfg.boost_ceiling  <= 5'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prq_pkg::CFG_QUANTUM: r_cfg.quantum_reload <= i_cfg_data;
                prq_pkg::CFG_CEILING: r_cfg.boost_ceiling  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= '{func: i_func, thread_id: i_thread_id, charge: i_charge,
                      boost: i_boost, new_priority: i_new_priority};
        end
    end

    prq_core #(
        .NUM_THREADS    (NUM_THREADS),
        .PRIORITY_LEVELS(PRIORITY_LEVELS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_item (r_in),
        .i_cfg  (r_cfg),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid          = r_out_v;
    assign o_status             = r_res.status;
    assign o_selected_valid     = r_res.sel_valid;
    assign o_selected_thread    = r_res.sel_thread;
    assign o_preempt_hint       = r_res.hint;
    assign o_prev_suspend_count = r_res.prev_susp;

endmodule
